// File: src/stli_pkg.sv
// Package for the sorted table linear interpolator.
// Holds widths, status codes, operation codes, the controller state type and the divider request and response types.
// No dependencies.
`timescale 1ns / 1ps

package stli_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W      = 24;
  localparam int STATUS_W    = 3;
  localparam int ENTRY_W     = 2 * DATA_W;
  localparam int NUM_W       = 2 * DATA_W + 2;
  localparam int DEN_W       = DATA_W + 1;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 3'd0,
    ST_FULL = 3'd1,
    ST_DUP  = 3'd2,
    ST_ZERO = 3'd3,
    ST_FEW  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DUP_RD,
    S_DUP_CHK,
    S_SHIFT_RD,
    S_SHIFT_CHK,
    S_LK_RD,
    S_LK_CHK,
    S_LK_HI,
    S_LK_MUL,
    S_DIV,
    S_DIV_END,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                     start;
    logic signed [NUM_W-1:0]  num;
    logic        [DEN_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [NUM_W-1:0]  quot;
  } div_rsp_t;

endpackage

// File: src/stli_if.sv
// Valid and ready channel interfaces for the interpolator.
// Depends on stli_pkg.
`timescale 1ns / 1ps

interface stli_in_if (input logic clk);
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic signed [stli_pkg::DATA_W-1:0]  power_in;
  logic signed [stli_pkg::DATA_W-1:0]  speed_in;
  modport source (output valid, op, power_in, speed_in, input ready);
  modport sink   (input valid, op, power_in, speed_in, output ready);
endinterface

interface stli_out_if (input logic clk);
  logic                                 valid;
  logic                                 ready;
  logic signed [stli_pkg::DATA_W-1:0]   speed_out;
  logic        [stli_pkg::STATUS_W-1:0] status;
  modport source (output valid, speed_out, status, input ready);
  modport sink   (input valid, speed_out, status, output ready);
endinterface

// File: src/sorted_table_linear_interpolator.sv
// Top level of the sorted table linear interpolator.
// Depends on stli_pkg, stli_if and stli_ctrl.
`timescale 1ns / 1ps

// One transaction at a time: the input is ready only while idle, and a result is
// held until taken, after which the controller returns to idle. An insert into
// n stored pairs reads and checks each entry for a duplicate key and then moves
// the larger entries up one place, reading and writing each in turn, before it
// writes the new pair; an insert into an empty table writes its pair directly,
// and a full table or zero power is answered at once. A lookup reads and checks
// entries until it finds the first key above the query, clamping to the first
// speed below the first key and to the last speed at or above the last key;
// interpolation then forms the difference and product, runs the 50-bit serial
// divider and adds the lower speed in a final step. Keys are strictly ascending
// signed Q8.16.
module sorted_table_linear_interpolator (
  input logic clk,
  input logic rst,
  stli_in_if.sink    in_ch,
  stli_out_if.source out_ch
);

  stli_ctrl u_ctrl (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

endmodule

// File: src/stli_ram.sv
// Generic simple dual port RAM, one write port and one read port, with a registered
// read. No dependencies.
`timescale 1ns / 1ps

module stli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/stli_div.sv
// Restoring serial divider, one quotient bit per cycle, truncating toward zero.
// Depends on stli_pkg.
`timescale 1ns / 1ps

module stli_div (
  input  logic                clk,
  input  logic                rst,
  input  stli_pkg::div_req_t  req,
  output stli_pkg::div_rsp_t  rsp
);
  import stli_pkg::*;

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  quot;
  logic [DEN_W:0]    rem;
  logic [DEN_W-1:0]  den;
  logic              neg;
  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    shifted;
  logic [NUM_W-1:0]  mag;

  always_comb begin
    mag     = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
    shifted = {rem[DEN_W-1:0], quot[NUM_W-1]};
    trial   = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= STEP_W'(NUM_W);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
    if (req.start) begin
      quot <= mag;
      rem  <= '0;
      den  <= req.den;
      neg  <= req.num[NUM_W-1];
    end else if (busy) begin
      if (!trial[DEN_W]) begin
        rem  <= trial;
        quot <= {quot[NUM_W-2:0], 1'b1};
      end else begin
        rem  <= shifted;
        quot <= {quot[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = neg ? -$signed(quot) : $signed(quot);

endmodule

// File: src/stli_ctrl.sv
// Sequencer that scans, shifts and reads the table memory for inserts and lookups.
// Depends on stli_pkg, stli_if, stli_ram and stli_div.
`timescale 1ns / 1ps

module stli_ctrl (
  input  logic clk,
  input  logic rst,
  stli_in_if.sink    in_ch,
  stli_out_if.source out_ch
);
  import stli_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        idx;
  logic signed [DATA_W-1:0] key;
  logic signed [DATA_W-1:0] spd;
  logic signed [DATA_W-1:0] lo_p, lo_s;
  logic signed [DATA_W-1:0] res_speed;
  logic [STATUS_W-1:0]     res_status;
  logic signed [NUM_W-1:0] prod;
  logic signed [DEN_W-1:0] dp;

  logic               we;
  logic [IDX_W-1:0]   waddr, raddr;
  logic [ENTRY_W-1:0] wdata, rdata;
  logic signed [DATA_W-1:0] rd_p, rd_s;

  div_req_t dreq;
  div_rsp_t drsp;

  stli_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  stli_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign rd_p = rdata[ENTRY_W-1:DATA_W];
  assign rd_s = rdata[DATA_W-1:0];

  assign in_ch.ready      = (state == S_IDLE);
  assign out_ch.valid     = (state == S_DONE);
  assign out_ch.speed_out = res_speed;
  assign out_ch.status    = res_status;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.op == OP_LOOKUP) begin
            state_next = (count < CNT_W'(2)) ? S_DONE : S_LK_RD;
          end else if (count >= CNT_W'(TABLE_DEPTH) || in_ch.power_in == '0) begin
            state_next = S_DONE;
          end else begin
            state_next = (count == '0) ? S_SHIFT_CHK : S_DUP_RD;
          end
        end
      end
      S_DUP_RD:    state_next = S_DUP_CHK;
      S_DUP_CHK: begin
        if (rd_p == key) state_next = S_DONE;
        else if (idx + 1'b1 == count) state_next = S_SHIFT_RD;
        else state_next = S_DUP_RD;
      end
      S_SHIFT_RD:  state_next = S_SHIFT_CHK;
      S_SHIFT_CHK: begin
        if (idx == '0 || rd_p < key) state_next = S_DONE;
        else state_next = S_SHIFT_RD;
      end
      S_LK_RD:     state_next = S_LK_CHK;
      S_LK_CHK: begin
        if (idx == '0 && key < rd_p) state_next = S_DONE;
        else if (key >= rd_p) state_next = (idx + 1'b1 == count) ? S_DONE : S_LK_RD;
        else state_next = S_LK_HI;
      end
      S_LK_HI:     state_next = S_LK_MUL;
      S_LK_MUL:    state_next = S_DIV;
      S_DIV:       state_next = drsp.done ? S_DIV_END : S_DIV;
      S_DIV_END:   state_next = S_DONE;
      S_DONE:      state_next = out_ch.ready ? S_IDLE : S_DONE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Memory and divider controls.
  always_comb begin
    we        = 1'b0;
    waddr     = idx[IDX_W-1:0];
    wdata     = {key, spd};
    raddr     = idx[IDX_W-1:0];
    dreq.start = (state == S_LK_MUL);
    dreq.num  = prod;
    dreq.den  = DEN_W'(dp);
    unique case (state)
      S_IDLE:     raddr = '0;
      S_SHIFT_RD: raddr = IDX_W'(idx - 1'b1);
      S_SHIFT_CHK: begin
        we = 1'b1;
        if (idx != '0 && !(rd_p < key)) wdata = rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == S_SHIFT_CHK && (idx == '0 || rd_p < key)) count <= count + 1'b1;
    end

    unique case (state)
      S_IDLE: begin
        key        <= in_ch.power_in;
        spd        <= in_ch.speed_in;
        idx        <= (in_ch.op == OP_INSERT) ? count : '0;
        res_speed  <= '0;
        res_status <= ST_OK;
        if (in_ch.op == OP_LOOKUP) begin
          if (count < CNT_W'(2)) res_status <= ST_FEW;
        end else if (count >= CNT_W'(TABLE_DEPTH)) begin
          res_status <= ST_FULL;
        end else if (in_ch.power_in == '0) begin
          res_status <= ST_ZERO;
        end else if (count != '0) begin
          idx <= '0;
        end
      end
      S_DUP_CHK: begin
        if (rd_p == key) res_status <= ST_DUP;
        else if (idx + 1'b1 == count) idx <= count;
        else idx <= idx + 1'b1;
      end
      S_SHIFT_CHK: begin
        if (!(idx == '0 || rd_p < key)) idx <= idx - 1'b1;
      end
      S_LK_CHK: begin
        if (idx == '0 && key < rd_p) begin
          res_speed <= rd_s;
        end else if (key >= rd_p) begin
          if (idx + 1'b1 == count) begin
            res_speed <= rd_s;
          end else begin
            lo_p <= rd_p;
            lo_s <= rd_s;
            idx  <= idx + 1'b1;
          end
        end
      end
      S_LK_HI: begin
        // Memory still holds the upper neighbour on its read port.
        dp   <= DEN_W'(rd_p) - DEN_W'(lo_p);
        prod <= (NUM_W'(DEN_W'(rd_s) - DEN_W'(lo_s))) * (NUM_W'(DEN_W'(key) - DEN_W'(lo_p)));
      end
      S_DIV_END: res_speed <= DATA_W'(drsp.quot + NUM_W'(lo_s));
      default: ;
    endcase
  end

endmodule
